### hdl/sdf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sdf_pkg;

    localparam int KEY_W       = 32;
    localparam int COUNT_W     = 9;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_PAD_W   = OUT_TDATA_W - KEY_W - COUNT_W;
    localparam int OUT_TUSER_W = 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic               keep;
        logic [COUNT_W-1:0] count;
        logic               last;
        logic               overflow;
    } result_t;

endpackage

`default_nettype wire

### hdl/sdf_core.sv
`timescale 1ns / 1ps
`default_nettype none

module sdf_core #(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_WIDTH   = 32
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output      logic                       in_ready,
    input  wire logic [sdf_pkg::KEY_W-1:0]  in_key,
    input  wire logic                       in_last,
    output      logic                       res_valid,
    input  wire logic                       res_ready,
    output      sdf_pkg::result_t           res
);

    localparam int STORE_W = (KEY_WIDTH < sdf_pkg::KEY_W) ? KEY_WIDTH : sdf_pkg::KEY_W;
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    sdf_pkg::state_t             state_reg, state_next;
    logic [sdf_pkg::KEY_W-1:0]   key_reg, key_next;
    logic                        last_reg, last_next;
    logic                        hit_reg, hit_next;
    logic                        pend_reg, pend_next;
    logic [CNT_W-1:0]            issue_reg, issue_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic                        ovf_reg, ovf_next;

    logic [STORE_W-1:0]          mem_array [TABLE_DEPTH];
    logic [STORE_W-1:0]          rd_data_reg;

    logic                        match;
    logic                        search_done;
    logic                        rd_en;
    logic                        wr_en;
    logic                        full;
    logic [CNT_W-1:0]            count_new;
    logic                        ovf_new;

    assign match       = pend_reg && (rd_data_reg == key_reg[STORE_W-1:0]);
    assign search_done = match || ((issue_reg == count_reg) && !pend_reg);
    assign full        = (count_reg == DEPTH_C);
    assign count_new   = (!hit_reg && !full) ? count_reg + CNT_W'(1) : count_reg;
    assign ovf_new     = ovf_reg || (!hit_reg && full);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sdf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (count_reg == '0) ? sdf_pkg::ST_FINISH : sdf_pkg::ST_SEARCH;
                end
            end
            sdf_pkg::ST_SEARCH:
            begin
                if (search_done)
                begin
                    state_next = sdf_pkg::ST_FINISH;
                end
            end
            sdf_pkg::ST_FINISH:
            begin
                if (res_ready)
                begin
                    state_next = sdf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sdf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        unique case (state_reg)
            sdf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            sdf_pkg::ST_SEARCH:
            begin
                rd_en = !match && (issue_reg != count_reg);
            end
            sdf_pkg::ST_FINISH:
            begin
                res_valid = 1'b1;
                wr_en     = res_ready && !hit_reg && !full;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        res.key      = key_reg;
        res.keep     = !hit_reg;
        res.count    = sdf_pkg::COUNT_W'(count_new);
        res.last     = last_reg;
        res.overflow = ovf_new;
    end

    always_comb
    begin
        key_next   = key_reg;
        last_next  = last_reg;
        hit_next   = hit_reg;
        pend_next  = pend_reg;
        issue_next = issue_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        case (state_reg)
            sdf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    key_next   = in_key;
                    last_next  = in_last;
                    hit_next   = 1'b0;
                    pend_next  = 1'b0;
                    issue_next = '0;
                end
            end
            sdf_pkg::ST_SEARCH:
            begin
                pend_next  = rd_en;
                issue_next = issue_reg + CNT_W'(rd_en);
                hit_next   = hit_reg || match;
            end
            sdf_pkg::ST_FINISH:
            begin
                if (res_ready)
                begin
                    count_next = last_reg ? '0 : count_new;
                    ovf_next   = last_reg ? 1'b0 : ovf_new;
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sdf_pkg::ST_IDLE;
            pend_reg  <= 1'b0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        last_reg  <= last_next;
        hit_reg   <= hit_next;
        issue_reg <= issue_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[count_reg[IDX_W-1:0]] <= key_reg[STORE_W-1:0];
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_array[issue_reg[IDX_W-1:0]];
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("Table fill count exceeds the table depth.");

    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sdf_pkg::ST_SEARCH) |-> (issue_reg <= count_reg))
        else $error("Search index ran past the filled part of the table.");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (count_reg == DEPTH_C))
        else $error("Overflow is set while the table still has room.");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready && res.last) |=> ((count_reg == '0) && !ovf_reg))
        else $error("Table was not cleared after the last transaction of a list.");
`endif

endmodule

`default_nettype wire

### hdl/sdf_outreg.sv
`timescale 1ns / 1ps
`default_nettype none

module sdf_outreg (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 res_valid,
    output      logic                                 res_ready,
    input  wire sdf_pkg::result_t                     res,
    output      logic                                 m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output      logic [sdf_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    output      logic [sdf_pkg::OUT_TUSER_W-1:0]      m_axis_tuser,
    output      logic                                 m_axis_tlast
);

    logic             valid_reg, valid_next;
    sdf_pkg::result_t data_reg;

    assign res_ready = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_ready)
        begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            data_reg <= res;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {{sdf_pkg::OUT_PAD_W{1'b0}}, data_reg.count, data_reg.key};
    assign m_axis_tuser  = {data_reg.overflow, data_reg.keep};
    assign m_axis_tlast  = data_reg.last;

endmodule

`default_nettype wire

### hdl/stream_duplicate_filter.sv
// Duplicate filter for lists of signed keys.
// The input stream carries one key per transaction; tlast marks the final key
// of a list. The output stream returns one transaction per input: the key, a
// keep flag that is set on a key's first occurrence in the list, the running
// count of distinct keys, the overflow flag and tlast copied from the input.
// Distinct keys live in a single-port-read, single-port-write table memory
// with a registered read port, searched one entry per cycle.
// The time a transaction takes is set by the linear scan of the table memory,
// which stops at a match or after the last stored key; while the table is
// empty the scan is skipped.
// A new key is accepted once the previous result sits in the output register.
// When the table is full, new keys are not stored, are passed with keep set,
// and raise overflow until the end of the list; the count stays at the depth.
// The table is emptied after the last transaction of each list.
// Reset empties the table and clears overflow; no clearing pass is needed.
// A stalled receiver holds the output register; one more result can finish
// behind it, after which the input side stops accepting.
`timescale 1ns / 1ps
`default_nettype none

module stream_duplicate_filter #(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_WIDTH   = 32
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_axis_tvalid,
    output      logic                                 s_axis_tready,
    // Bits from low: key (32).
    input  wire logic [sdf_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    input  wire logic                                 s_axis_tlast,
    output      logic                                 m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // Bits from low: key_out (32), distinct_count (9), zero padding (7).
    output      logic [sdf_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // Bits from low: keep (1), overflow (1).
    output      logic [sdf_pkg::OUT_TUSER_W-1:0]      m_axis_tuser,
    output      logic                                 m_axis_tlast
);

    logic             res_valid;
    logic             res_ready;
    sdf_pkg::result_t res;

    sdf_core #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_key    (s_axis_tdata[sdf_pkg::KEY_W-1:0]),
        .in_last   (s_axis_tlast),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    sdf_outreg u_outreg (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

### dv/tb_stream_duplicate_filter.sv
`timescale 1ns / 1ps

module tb_stream_duplicate_filter;

    localparam int TABLE_DEPTH = 256;
    localparam int ITEM_TARGET = 1350;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [sdf_pkg::IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                             s_axis_tlast = 1'b0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [sdf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;
    logic [sdf_pkg::OUT_TUSER_W-1:0]  m_axis_tuser;
    logic                             m_axis_tlast;

    logic [sdf_pkg::KEY_W-1:0] seen_table[$];
    bit                        list_overflow = 1'b0;
    sdf_pkg::result_t          expected_results[$];

    bit steady = 1'b0;
    int errors = 0;
    int keys_sent = 0;
    int lists_sent = 0;
    int repeats_dropped = 0;
    int overflow_results = 0;

    stream_duplicate_filter #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .KEY_WIDTH(sdf_pkg::KEY_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit take_break();
        return !steady && ($urandom_range(0, 99) < 25);
    endfunction

    function automatic sdf_pkg::result_t filter_predict(logic [sdf_pkg::KEY_W-1:0] k, logic l);
        sdf_pkg::result_t r;
        bit found;
        found = 1'b0;
        foreach (seen_table[i])
        begin
            if (seen_table[i] == k)
                found = 1'b1;
        end
        if (!found)
        begin
            if (seen_table.size() < TABLE_DEPTH)
                seen_table.push_back(k);
            else
                list_overflow = 1'b1;
        end
        r.key      = k;
        r.keep     = !found;
        r.count    = sdf_pkg::COUNT_W'(seen_table.size());
        r.last     = l;
        r.overflow = list_overflow;
        if (l)
        begin
            seen_table.delete();
            list_overflow = 1'b0;
        end
        return r;
    endfunction

    task automatic send_key(input logic [sdf_pkg::KEY_W-1:0] k, input logic l);
        if (take_break())
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while (take_break());
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= k;
        s_axis_tlast  <= l;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_results.push_back(filter_predict(k, l));
        keys_sent++;
        if (l)
            lists_sent++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_result();
        sdf_pkg::result_t want;
        if (expected_results.size() == 0)
        begin
            $display("%0t: unexpected transaction, expected none, actual key %0h",
                     $time, m_axis_tdata[sdf_pkg::KEY_W-1:0]);
            errors++;
        end
        else
        begin
            want = expected_results.pop_front();
            compare_field("key_out", want.key, m_axis_tdata[sdf_pkg::KEY_W-1:0]);
            compare_field("distinct_count", 32'(want.count),
                          32'(m_axis_tdata[sdf_pkg::KEY_W +: sdf_pkg::COUNT_W]));
            compare_field("keep", 32'(want.keep), 32'(m_axis_tuser[0]));
            compare_field("overflow", 32'(want.overflow), 32'(m_axis_tuser[1]));
            compare_field("last_out", 32'(want.last), 32'(m_axis_tlast));
            if (!want.keep)
                repeats_dropped++;
            if (want.overflow)
                overflow_results++;
        end
    endtask

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            check_result();
        m_axis_tready <= !take_break();
    end

    task automatic test_extreme_keys();
        send_key(32'h8000_0000, 1'b0);
        send_key(32'h7FFF_FFFF, 1'b0);
        send_key(32'h0000_0000, 1'b0);
        send_key(32'hFFFF_FFFF, 1'b0);
        send_key(32'h8000_0000, 1'b0);
        send_key(32'hFFFF_FFFF, 1'b0);
        send_key(32'h0000_0001, 1'b0);
        send_key(32'h7FFF_FFFF, 1'b1);
    endtask

    task automatic test_short_lists();
        logic [31:0] k;
        k = $urandom;
        send_key(k, 1'b1);
        send_key(k, 1'b1);
        send_key(32'h0000_0000, 1'b1);
        for (int i = 0; i < 4; i++)
            send_key(k, i == 3);
    endtask

    task automatic test_near_keys();
        send_key(32'h5555_5555, 1'b0);
        send_key(32'h5555_5554, 1'b0);
        send_key(32'hD555_5555, 1'b0);
        send_key(32'hAAAA_AAAA, 1'b0);
        send_key(32'h5555_5555, 1'b1);
    endtask

    task automatic test_table_full();
        logic [31:0] base;
        logic [31:0] stride;
        base   = $urandom;
        stride = $urandom | 32'd1;
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_key(base + 32'(i) * stride, i == TABLE_DEPTH - 1);
        base   = $urandom;
        stride = $urandom | 32'd1;
        for (int i = 0; i < TABLE_DEPTH + 6; i++)
            send_key(base + 32'(i) * stride, 1'b0);
        send_key(base + 32'd3 * stride, 1'b0);
        send_key(base + 32'(TABLE_DEPTH + 2) * stride, 1'b0);
        send_key(base, 1'b1);
    endtask

    task automatic test_random_lists();
        logic [31:0] pool[8];
        logic [31:0] k;
        int len;
        int choice;
        while (keys_sent < ITEM_TARGET)
        begin
            steady = (keys_sent > 950) && (keys_sent < 1150);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16);
            foreach (pool[i])
                pool[i] = $urandom;
            for (int n = 0; n < len; n++)
            begin
                choice = $urandom_range(0, 99);
                if (choice < 60)
                    k = pool[$urandom_range(0, 7)];
                else if (choice < 90)
                    k = $urandom;
                else
                    k = pool[$urandom_range(0, 7)] ^ (32'd1 << $urandom_range(0, 31));
                send_key(k, n == len - 1);
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extreme_keys();
        test_short_lists();
        test_near_keys();
        test_table_full();
        test_random_lists();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (TABLE_DEPTH + 16) @(posedge clk);
        $display("Sent %0d keys in %0d lists, including extreme keys and full tables.",
                 keys_sent, lists_sent);
        $display("Saw %0d repeats dropped and %0d results with overflow set.",
                 repeats_dropped, overflow_results);
        if (errors == 0)
            $display("tb_stream_duplicate_filter passed");
        else
            $display("tb_stream_duplicate_filter failed");
        $finish;
    end

    initial
    begin
        #25_000_000;
        $display("Timeout with %0d transactions still expected.", expected_results.size());
        $display("tb_stream_duplicate_filter failed");
        $finish;
    end

endmodule

### files.f
hdl/sdf_pkg.sv
hdl/sdf_core.sv
hdl/sdf_outreg.sv
hdl/stream_duplicate_filter.sv
dv/tb_stream_duplicate_filter.sv
